FILE: rtl/core/usg_pkg.sv
// Shared types, codes and constants for the UV sphere grid-point generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package usg_pkg;

	localparam int IDX_W      = 9;
	localparam int CNT_W      = 9;
	localparam int RAD_W      = 16;
	localparam int VAL_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int QUOT_W     = 33;
	localparam int TEX_W      = 17;
	localparam int DIV_STEPS  = 33;
	localparam int CORDIC_STEPS = 28;
	localparam int ITEM_GAP   = 5;
	localparam int GAP_W      = 3;
	localparam int SLOTS      = 5;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	typedef enum logic [2:0] {
		KIND_POS = 3'd0,
		KIND_NRM = 3'd1,
		KIND_TEX = 3'd2,
		KIND_TRI = 3'd3,
		KIND_REJ = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STACKS = 3'd0,
		REG_SECTORS = 3'd1,
		REG_RADIUS = 3'd2,
		REG_UP = 3'd3
	} reg_idx_t;

	localparam logic [1:0] UP_X = 2'd1;
	localparam logic [1:0] UP_Z = 2'd3;

	typedef struct packed {
		logic             valid;
		logic             rej;
		logic             has_up;
		logic             has_lo;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} side_t;

	typedef struct packed {
		logic [CNT_W-1:0]  rem;
		logic              bit_in;
		logic [QUOT_W-1:0] quot;
	} div_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
		logic [1:0]         quad;
	} cordic_t;

	typedef struct packed {
		logic [TEX_W-1:0] s;
		logic [TEX_W-1:0] t;
	} tex_t;

	typedef struct packed {
		logic                             valid;
		logic                             rej;
		logic [SLOTS-1:0]                 mask;
		logic [SLOTS-1:0][2:0][VAL_W-1:0] vals;
	} bundle_t;

endpackage
`default_nettype wire

FILE: rtl/core/usg_div_cell.sv
// One restoring division cell: a single quotient bit per cycle.
// Depends on usg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usg_div_cell (
	input  logic                           clk,
	input  logic [usg_pkg::CNT_W-1:0]      divisor,
	input  usg_pkg::div_t                  d_in,
	output usg_pkg::div_t                  d_out
);
	import usg_pkg::*;

	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic           ge;
	div_t           d_q;

	assign trial = {d_in.rem, d_in.bit_in};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		d_q.rem    <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		d_q.bit_in <= 1'b0;
		d_q.quot   <= {d_in.quot[QUOT_W-2:0], ge};
	end

	assign d_out = d_q;
endmodule
`default_nettype wire

FILE: rtl/core/usg_cordic_cell.sv
// One rotation-mode CORDIC cell of the sine and cosine chain.
// Depends on usg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usg_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  usg_pkg::cordic_t d_in,
	output usg_pkg::cordic_t d_out
);
	import usg_pkg::*;

	logic signed [33:0] sx;
	logic signed [33:0] sy;
	logic signed [32:0] ang;
	cordic_t            d_q;

	assign sx  = d_in.y >>> STEP;
	assign sy  = d_in.x >>> STEP;
	assign ang = $signed({1'b0, ATAN_TAB[STEP]});

	always_ff @(posedge clk) begin
		d_q.quad <= d_in.quad;
		if (!d_in.z[32]) begin
			d_q.x <= d_in.x - sx;
			d_q.y <= d_in.y + sy;
			d_q.z <= d_in.z - ang;
		end else begin
			d_q.x <= d_in.x + sx;
			d_q.y <= d_in.y - sy;
			d_q.z <= d_in.z + ang;
		end
	end

	assign d_out = d_q;
endmodule
`default_nettype wire

FILE: rtl/core/usg_tail.sv
// Products, rounding, axis remap and triangle indices after the CORDIC chain.
// Depends on usg_pkg; feeds a result bundle to usg_emit.
`timescale 1ns / 1ps
`default_nettype none
module usg_tail (
	input  logic                        clk,
	input  logic                        arst_n,
	input  usg_pkg::cordic_t            cor_t,
	input  usg_pkg::cordic_t            cor_l,
	input  usg_pkg::side_t              side_in,
	input  usg_pkg::tex_t               tex_in,
	input  logic [usg_pkg::CNT_W-1:0]   sectors,
	input  logic [usg_pkg::RAD_W-1:0]   radius,
	input  logic [1:0]                  up_axis,
	output usg_pkg::bundle_t            bundle
);
	import usg_pkg::*;

	function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
		if (v > 34'sd1073741824) begin
			return 32'sd1073741824;
		end else if (v < -34'sd1073741824) begin
			return -32'sd1073741824;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] rot(input cordic_t c);
		logic signed [31:0] x;
		logic signed [31:0] y;
		x = clamp_unit(c.x);
		y = clamp_unit(c.y);
		case (c.quad)
			2'd0: begin
				return {x, y};
			end
			2'd1: begin
				return {-y, x};
			end
			2'd2: begin
				return {-x, -y};
			end
			default: begin
				return {y, -x};
			end
		endcase
	endfunction

	side_t side_s1, side_s2, side_s3, side_s4;
	tex_t  tex_s1, tex_s2, tex_s3, tex_s4;

	logic signed [63:0] rt, rl;
	logic signed [31:0] ct_s1, st_s1, cv_s1, sv_s1;
	logic signed [63:0] pc_s2, ps_s2;
	logic signed [31:0] ct_s2;
	logic signed [63:0] rc, rs;
	logic signed [31:0] n0, n1, n2;
	logic signed [31:0] m0, m1, m2;
	logic signed [31:0] n_s3 [3];
	logic signed [48:0] pr_s4 [3];
	logic [VAL_W-1:0]   nrm_s4 [3];
	logic [19:0]        k1_s4;
	logic [CNT_W:0]     sec1;
	logic [18:0]        kprod;
	logic signed [48:0] rnd_pos [3];
	logic [19:0]        k2;

	assign rt = rot(cor_t);
	assign rl = rot(cor_l);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		tex_s1 <= tex_in;
		tex_s2 <= tex_s1;
		tex_s3 <= tex_s2;
		tex_s4 <= tex_s3;
		ct_s1  <= rt[63:32];
		st_s1  <= rt[31:0];
		cv_s1  <= rl[63:32];
		sv_s1  <= rl[31:0];
	end

	always_ff @(posedge clk) begin
		pc_s2 <= st_s1 * cv_s1;
		ps_s2 <= st_s1 * sv_s1;
		ct_s2 <= ct_s1;
	end

	assign rc = (pc_s2 + (64'sd1 <<< 29)) >>> 30;
	assign rs = (ps_s2 + (64'sd1 <<< 29)) >>> 30;
	assign n0 = clamp_unit(rc[33:0]);
	assign n1 = clamp_unit(rs[33:0]);
	assign n2 = ct_s2;

	always_comb begin
		m0 = n0;
		m1 = n1;
		m2 = n2;
		if (up_axis == UP_X) begin
			m0 = n2;
			m2 = -n0;
		end else if (up_axis != UP_Z) begin
			m1 = n2;
			m2 = -n1;
		end
	end

	always_ff @(posedge clk) begin
		n_s3[0] <= m0;
		n_s3[1] <= m1;
		n_s3[2] <= m2;
	end

	assign sec1  = {1'b0, sectors} + 10'd1;
	assign kprod = side_s3.i * sec1;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pr_s4[k]  <= $signed({1'b0, radius}) * n_s3[k];
			nrm_s4[k] <= VAL_W'((n_s3[k] + 32'sd32768) >>> 16);
		end
		k1_s4 <= {1'b0, kprod} + {11'd0, side_s3.j};
	end

	assign k2 = k1_s4 + {10'd0, sec1};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd_pos[k] = (pr_s4[k] + (49'sd1 <<< 29)) >>> 30;
		end
		bundle.valid = side_s4.valid;
		bundle.rej   = side_s4.rej;
		bundle.vals  = '0;
		bundle.mask  = {side_s4.has_lo, side_s4.has_up, 3'b111};
		if (side_s4.rej) begin
			bundle.mask = 5'b00001;
		end else begin
			for (int k = 0; k < 3; k++) begin
				bundle.vals[0][k] = rnd_pos[k][VAL_W-1:0];
				bundle.vals[1][k] = nrm_s4[k];
			end
			bundle.vals[2][0] = {1'b0, tex_s4.s};
			bundle.vals[2][1] = {1'b0, tex_s4.t};
			bundle.vals[3][0] = k1_s4[VAL_W-1:0];
			bundle.vals[3][1] = k2[VAL_W-1:0];
			bundle.vals[3][2] = k1_s4[VAL_W-1:0] + 18'd1;
			bundle.vals[4][0] = k1_s4[VAL_W-1:0] + 18'd1;
			bundle.vals[4][1] = k2[VAL_W-1:0];
			bundle.vals[4][2] = k2[VAL_W-1:0] + 18'd1;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/usg_emit.sv
// Holds one result bundle and sends its results one per cycle.
// Depends on usg_pkg; fed by usg_tail.
`timescale 1ns / 1ps
`default_nettype none
module usg_emit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  usg_pkg::bundle_t                bundle,
	output logic                            result_valid,
	output usg_pkg::kind_t                  kind,
	output logic                            last,
	output logic signed [usg_pkg::VAL_W-1:0] value_a,
	output logic signed [usg_pkg::VAL_W-1:0] value_b,
	output logic signed [usg_pkg::VAL_W-1:0] value_c
);
	import usg_pkg::*;

	logic [SLOTS-1:0]                 pending_q;
	logic [SLOTS-1:0][2:0][VAL_W-1:0] vals_q;
	logic                             rej_q;
	logic [2:0]                       slot;
	logic [SLOTS-1:0]                 pick;
	kind_t                            kind_d;
	logic                             valid_q;
	kind_t                            kind_q;
	logic                             last_q;
	logic [VAL_W-1:0]                 a_q, b_q, c_q;

	always_comb begin
		slot = 3'd0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (pending_q[k]) begin
				slot = 3'(k);
			end
		end
		pick = SLOTS'(1) << slot;
		case (slot)
			3'd0: begin
				kind_d = rej_q ? KIND_REJ : KIND_POS;
			end
			3'd1: begin
				kind_d = KIND_NRM;
			end
			3'd2: begin
				kind_d = KIND_TEX;
			end
			default: begin
				kind_d = KIND_TRI;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= |pending_q;
			if (bundle.valid) begin
				pending_q <= bundle.mask;
			end else begin
				pending_q <= pending_q & ~pick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bundle.valid) begin
			vals_q <= bundle.vals;
			rej_q  <= bundle.rej;
		end
		kind_q <= kind_d;
		last_q <= (pending_q & ~pick) == '0;
		a_q    <= vals_q[slot][0];
		b_q    <= vals_q[slot][1];
		c_q    <= vals_q[slot][2];
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign last         = last_q;
	assign value_a      = a_q;
	assign value_b      = b_q;
	assign value_c      = c_q;
endmodule
`default_nettype wire

FILE: rtl/core/uv_sphere_vertex_and_index_generator.sv
// Top level of the UV sphere grid-point generator: registers, division and CORDIC cell chains.
// Depends on usg_pkg, usg_div_cell, usg_cordic_cell, usg_tail and usg_emit.
//
// Channel   Handshake                 Payload
// command   start / busy              stack_index, sector_index
// result    result_valid (strobe)     kind, last, value_a, value_b, value_c
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An item is taken only while busy is low; busy then rises and holds a gap before the next item.
// The gap matches the five result slots that one item can put on the single result port.
// Results of an item pass through the input register, 33 division cells,
// 28 CORDIC cells, four product and rounding stages, the bundle register and the output register.
// Reset clears the registers to their defaults; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_vertex_and_index_generator #(
	parameter int MAX_STACKS  = 256,
	parameter int MAX_SECTORS = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [usg_pkg::IDX_W-1:0]             stack_index,
	input  logic [usg_pkg::IDX_W-1:0]             sector_index,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [usg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [usg_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                  result_valid,
	output usg_pkg::kind_t                        kind,
	output logic                                  last,
	output logic signed [usg_pkg::VAL_W-1:0]      value_a,
	output logic signed [usg_pkg::VAL_W-1:0]      value_b,
	output logic signed [usg_pkg::VAL_W-1:0]      value_c
);
	import usg_pkg::*;

	localparam logic [10:0] MAX_ST = 11'(MAX_STACKS);
	localparam logic [10:0] MAX_SE = 11'(MAX_SECTORS);
	localparam int SIDE_LEN = DIV_STEPS + CORDIC_STEPS + 1;

	logic [CNT_W-1:0] stack_count_q, sector_count_q;
	logic [RAD_W-1:0] radius_q;
	logic [1:0]       up_axis_q;
	logic [CNT_W-1:0] stacks, sectors;
	logic [GAP_W-1:0] gap_q;
	logic             accept;
	side_t            side_d;
	side_t            side_q [SIDE_LEN];
	tex_t             tex_q [CORDIC_STEPS];
	div_t             div_i [DIV_STEPS+1];
	div_t             div_j [DIV_STEPS+1];
	cordic_t          cor_t [CORDIC_STEPS+1];
	cordic_t          cor_l [CORDIC_STEPS+1];
	logic [31:0]      theta, lon;
	bundle_t          bundle;

	assign stacks  = (stack_count_q < 9'd2) ? 9'd2 :
		({2'b0, stack_count_q} > MAX_ST) ? MAX_ST[CNT_W-1:0] : stack_count_q;
	assign sectors = (sector_count_q < 9'd2) ? 9'd2 :
		({2'b0, sector_count_q} > MAX_SE) ? MAX_SE[CNT_W-1:0] : sector_count_q;

	assign cfg_ready = 1'b1;
	assign busy      = gap_q != '0;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q  <= 9'd18;
			sector_count_q <= 9'd36;
			radius_q       <= 16'd256;
			up_axis_q      <= UP_Z;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STACKS: begin
					stack_count_q <= cfg_data[CNT_W-1:0];
				end
				REG_SECTORS: begin
					sector_count_q <= cfg_data[CNT_W-1:0];
				end
				REG_RADIUS: begin
					radius_q <= cfg_data[RAD_W-1:0];
				end
				REG_UP: begin
					up_axis_q <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= GAP_W'(ITEM_GAP - 1);
		end else if (busy) begin
			gap_q <= gap_q - 1'b1;
		end
	end

	always_comb begin
		side_d.valid  = accept;
		side_d.i      = stack_index;
		side_d.j      = sector_index;
		side_d.rej    = (stack_index > stacks) || (sector_index > sectors);
		side_d.has_up = (stack_index < stacks) && (sector_index < sectors) &&
			(stack_index != '0);
		side_d.has_lo = (stack_index < stacks) && (sector_index < sectors) &&
			(stack_index != stacks - 9'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIDE_LEN; k++) begin
				side_q[k] <= '0;
			end
		end else begin
			side_q[0] <= side_d;
			for (int k = 1; k < SIDE_LEN; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign div_i[0] = '{rem: {1'b0, side_q[0].i[IDX_W-1:1]}, bit_in: side_q[0].i[0], quot: '0};
	assign div_j[0] = '{rem: {1'b0, side_q[0].j[IDX_W-1:1]}, bit_in: side_q[0].j[0], quot: '0};

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		usg_div_cell u_div_i (.clk(clk), .divisor(stacks),  .d_in(div_i[g]), .d_out(div_i[g+1]));
		usg_div_cell u_div_j (.clk(clk), .divisor(sectors), .d_in(div_j[g]), .d_out(div_j[g+1]));
	end

	assign theta = div_i[DIV_STEPS].quot[QUOT_W-1:1];
	assign lon   = div_j[DIV_STEPS].quot[31:0];

	assign cor_t[0] = '{x: CORDIC_GAIN, y: '0, z: {3'b000, theta[29:0]}, quad: theta[31:30]};
	assign cor_l[0] = '{x: CORDIC_GAIN, y: '0, z: {3'b000, lon[29:0]}, quad: lon[31:30]};

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		usg_cordic_cell #(.STEP(g)) u_cor_t (.clk(clk), .d_in(cor_t[g]), .d_out(cor_t[g+1]));
		usg_cordic_cell #(.STEP(g)) u_cor_l (.clk(clk), .d_in(cor_l[g]), .d_out(cor_l[g+1]));
	end

	always_ff @(posedge clk) begin
		tex_q[0].t <= div_i[DIV_STEPS].quot[QUOT_W-1:QUOT_W-TEX_W];
		tex_q[0].s <= div_j[DIV_STEPS].quot[QUOT_W-1:QUOT_W-TEX_W];
		for (int k = 1; k < CORDIC_STEPS; k++) begin
			tex_q[k] <= tex_q[k-1];
		end
	end

	usg_tail u_tail (
		.clk     (clk),
		.arst_n  (arst_n),
		.cor_t   (cor_t[CORDIC_STEPS]),
		.cor_l   (cor_l[CORDIC_STEPS]),
		.side_in (side_q[SIDE_LEN-1]),
		.tex_in  (tex_q[CORDIC_STEPS-1]),
		.sectors (sectors),
		.radius  (radius_q),
		.up_axis (up_axis_q),
		.bundle  (bundle)
	);

	usg_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.bundle       (bundle),
		.result_valid (result_valid),
		.kind         (kind),
		.last         (last),
		.value_a      (value_a),
		.value_b      (value_b),
		.value_c      (value_c)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy low after an item was taken");
	a_rej_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_REJ) |-> last) else $error("rejected result not last");
	a_pos_then_nrm: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_POS) |=> (result_valid && kind == KIND_NRM))
		else $error("normal does not follow position");
	a_tex_then_tri: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_TEX && !last) |=> (result_valid && kind == KIND_TRI))
		else $error("texcoord not followed by a triangle");
`endif
endmodule
`default_nettype wire

FILE: test/uv_sphere_vertex_and_index_generator_test.sv
// Self-checking bench for the UV sphere grid-point generator: drives grid points and
// register writes, predicts every result in fixed point and compares them in order.
// Depends on usg_pkg and the uv_sphere_vertex_and_index_generator top level.
`timescale 1ns / 1ps
module uv_sphere_vertex_and_index_generator_test;
	import usg_pkg::*;

	typedef struct {
		kind_t            k;
		logic             lst;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
		logic [VAL_W-1:0] c;
	} vertex_rec_t;

	localparam int PIPE_WAIT = 120;
	localparam int MAX_COUNT = 256;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [31:0] ATAN [28] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [IDX_W-1:0] stack_index = '0;
	logic [IDX_W-1:0] sector_index = '0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic busy, cfg_ready, result_valid, last;
	kind_t kind;
	logic signed [VAL_W-1:0] value_a, value_b, value_c;

	logic [8:0] m_stacks = 9'd18;
	logic [8:0] m_sectors = 9'd36;
	logic [15:0] m_radius = 16'd256;
	logic [1:0] m_up = 2'd3;

	vertex_rec_t pending[$];
	int errors = 0;
	longint cycles = 0;
	bit gaps_on = 1'b1;

	uv_sphere_vertex_and_index_generator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stack_index(stack_index), .sector_index(sector_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .kind(kind), .last(last),
		.value_a(value_a), .value_b(value_b), .value_c(value_c)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint fshift(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint rshift(longint v, int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic longint unit_clamp(longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	task automatic trig(input logic [31:0] ang, output longint co, output longint si);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = longint'(ang[29:0]);
		for (int k = 0; k < 28; k++) begin
			dx = fshift(y, k);
			dy = fshift(x, k);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN[k]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN[k]);
			end
		end
		x = unit_clamp(x);
		y = unit_clamp(y);
		case (ang[31:30])
			2'd0: begin co = x; si = y; end
			2'd1: begin co = -y; si = x; end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endtask

	task automatic push_rec(input kind_t k, input longint a, input longint b, input longint c);
		vertex_rec_t r;
		r.k = k;
		r.lst = 1'b0;
		r.a = a[VAL_W-1:0];
		r.b = b[VAL_W-1:0];
		r.c = c[VAL_W-1:0];
		pending.insert(pending.size(), r);
	endtask

	task automatic predict_point(input logic [8:0] i9, input logic [8:0] j9);
		longint unsigned st, se, i, j, k1, k2;
		longint ct, sth, cv, sv, t0, r;
		longint n[3];
		st = (m_stacks < 2) ? 2 : m_stacks;
		se = (m_sectors < 2) ? 2 : m_sectors;
		if (st > MAX_COUNT) st = MAX_COUNT;
		if (se > MAX_COUNT) se = MAX_COUNT;
		i = i9;
		j = j9;
		if (i > st || j > se) begin
			push_rec(KIND_REJ, 0, 0, 0);
		end else begin
			trig(32'((i << 31) / st), ct, sth);
			trig(32'((j << 32) / se), cv, sv);
			n[0] = unit_clamp(rshift(sth * cv, 30));
			n[1] = unit_clamp(rshift(sth * sv, 30));
			n[2] = ct;
			if (m_up == UP_X) begin
				t0 = n[0]; n[0] = n[2]; n[2] = -t0;
			end else if (m_up != UP_Z) begin
				t0 = n[1]; n[1] = n[2]; n[2] = -t0;
			end
			r = m_radius;
			push_rec(KIND_POS, rshift(r * n[0], 30), rshift(r * n[1], 30),
				rshift(r * n[2], 30));
			push_rec(KIND_NRM, rshift(n[0], 16), rshift(n[1], 16), rshift(n[2], 16));
			push_rec(KIND_TEX, longint'((j << 16) / se), longint'((i << 16) / st), 0);
			if (i < st && j < se) begin
				k1 = i * (se + 1) + j;
				k2 = k1 + se + 1;
				if (i != 0) push_rec(KIND_TRI, k1, k2, k1 + 1);
				if (i != st - 1) push_rec(KIND_TRI, k1 + 1, k2, k2 + 1);
			end
		end
		pending[$].lst = 1'b1;
	endtask

	always @(posedge clk) begin
		vertex_rec_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
		if (arst_n && result_valid) begin
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result kind %0d", kind);
			end else begin
				e = pending.pop_front();
				if (kind !== e.k || last !== e.lst || value_a !== e.a
						|| value_b !== e.b || value_c !== e.c) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp k%0d l%0b %h %h %h got k%0d l%0b %h %h %h",
							e.k, e.lst, e.a, e.b, e.c, kind, last, value_a, value_b, value_c);
				end
			end
		end
	end

	task automatic idle_burst();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic send_point(input logic [8:0] i, input logic [8:0] j);
		idle_burst();
		start <= 1'b1;
		stack_index <= i;
		sector_index <= j;
		do @(posedge clk); while (busy);
		predict_point(i, j);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_STACKS: m_stacks = d[8:0];
			REG_SECTORS: m_sectors = d[8:0];
			REG_RADIUS: m_radius = d;
			REG_UP: m_up = d[1:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [15:0] s, input logic [15:0] c, input logic [15:0] r,
			input logic [15:0] u);
		drain();
		write_reg(REG_STACKS, s);
		write_reg(REG_SECTORS, c);
		write_reg(REG_RADIUS, r);
		write_reg(REG_UP, u);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_point(9'd0, 9'd0);
		send_point(9'd18, 9'd36);
		send_point(9'd17, 9'd35);
		send_point(9'd9, 9'd18);
		send_point(9'd19, 9'd0);
		send_point(9'd0, 9'd37);
		send_point(9'h1FF, 9'h1FF);
		set_all(16'd2, 16'd2, 16'hFFFF, 16'd1);
		for (int i = 0; i <= 2; i++)
			for (int j = 0; j <= 2; j++) send_point(9'(i), 9'(j));
		set_all(16'd0, 16'd511, 16'd0, 16'd0);
		send_point(9'd1, 9'd255);
		send_point(9'd2, 9'd256);
		send_point(9'd3, 9'd0);
		set_all(16'd256, 16'd1, 16'hFFFF, 16'd2);
		send_point(9'd256, 9'd2);
		send_point(9'd255, 9'd1);
		send_point(9'd128, 9'd0);
		send_point(9'd257, 9'd1);
	endtask

	task automatic test_random(input int n);
		logic [8:0] st, se;
		st = (m_stacks < 2) ? 9'd2 : (m_stacks > 256 ? 9'd256 : m_stacks);
		se = (m_sectors < 2) ? 9'd2 : (m_sectors > 256 ? 9'd256 : m_sectors);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_point(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
			else
				send_point(9'($urandom_range(0, st)), 9'($urandom_range(0, se)));
		end
	endtask

	task automatic test_configs();
		for (int p = 0; p < 6; p++) begin
			set_all(16'($urandom_range(0, 511)), 16'($urandom_range(0, 511)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3)));
			test_random(45);
		end
		set_all(16'd256, 16'd256, 16'd65535, 16'd3);
		test_random(30);
		gaps_on = 1'b0;
		set_all(16'($urandom_range(2, 40)), 16'($urandom_range(2, 40)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(1, 3)));
		test_random(50);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_configs();
		drain();
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
